[rtl/oal_pkg.sv]
`timescale 1ns / 1ps

package oal_pkg;

  localparam int MODE_W   = 3;
  localparam int INDEX_W  = 7;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  typedef enum logic [MODE_W-1:0] {
    OP_INSERT,
    OP_APPEND,
    OP_SET,
    OP_GET,
    OP_REMOVE_AT,
    OP_REMOVE_VALUE,
    OP_CLEAR,
    OP_SIZE
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK,
    STAT_RANGE,
    STAT_FULL
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP,
    S_DOWN,
    S_COMPACT,
    S_SET,
    S_GET,
    S_GET_WAIT,
    S_EMIT
  } state_t;

endpackage

[rtl/oal_if.sv]
`timescale 1ns / 1ps

interface oal_req_if import oal_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [INDEX_W-1:0] index;
  logic [DATA_W-1:0]  value;

  modport source (output valid, mode, index, value, input ready);
  modport sink   (input valid, mode, index, value, output ready);
endinterface

interface oal_rsp_if import oal_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [DATA_W-1:0]   read_value;
  logic [COUNT_W-1:0]  removed_count;
  logic [COUNT_W-1:0]  list_length;

  modport source (output valid, status, read_value, removed_count, list_length, input ready);
  modport sink   (input valid, status, read_value, removed_count, list_length, output ready);
endinterface

[rtl/oal_ram.sv]
`timescale 1ns / 1ps

module oal_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[rtl/ordered_array_list_engine_top.sv]
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY words held in a memory with one write port and one registered
// read port, with one request in flight at a time (ready is high only when idle). Clear, size and
// any rejected request go straight from the accepting edge to the result. Set writes the word
// before the result, and get reads the entry and waits for the registered read data. Insert and
// append shift the tail up one entry per cycle and then write the new word. Remove at index
// shifts the tail down. Remove value reads every entry once and writes back the entries that do
// not match. The worst case is a full-length shift or compaction. The one-entry-per-cycle pace
// is set by the memory's single read and write port. A finished result sits in an output register
// until taken. A result that cannot move in stalls the engine, and the next request is accepted
// the cycle after that result has moved in.
module ordered_array_list_engine_top
  import oal_pkg::*;
#(
  parameter int CAPACITY    = 64,
  parameter int VALUE_WIDTH = 32
) (
  input logic      clk,
  input logic      rst,
  oal_req_if.sink  req,
  oal_rsp_if.source rsp
);

  localparam int AW    = $clog2(CAPACITY);
  localparam int LEN_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = ((LEN_W > INDEX_W) ? LEN_W : INDEX_W) + 1;

  state_t state, state_next;

  logic [LEN_W-1:0]       length;
  logic [LEN_W-1:0]       pos;
  logic [LEN_W-1:0]       k;
  logic [LEN_W-1:0]       kept;
  logic [VALUE_WIDTH-1:0] word;
  logic                   pend;
  logic [AW-1:0]          pend_addr;
  status_t                res_status;
  logic [DATA_W-1:0]      res_read;
  logic [COUNT_W-1:0]     res_removed;

  logic                   out_valid;
  status_t                out_status;
  logic [DATA_W-1:0]      out_read;
  logic [COUNT_W-1:0]     out_removed;
  logic [COUNT_W-1:0]     out_length;

  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [VALUE_WIDTH-1:0] mem_wdata;
  logic [AW-1:0]          mem_raddr;
  logic [VALUE_WIDTH-1:0] mem_rdata;

  logic                   accept;
  op_t                    op;
  logic [CMP_W-1:0]       req_pos;
  logic [CMP_W-1:0]       req_pos_inc;
  logic [CMP_W-1:0]       len_ext;
  logic                   ins_range;
  logic                   idx_range;
  logic                   full;
  status_t                req_status;
  logic [LEN_W-1:0]       k_dec;
  logic [LEN_W-1:0]       removed_diff;
  logic                   walk_done;
  logic                   emit_go;

  oal_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (VALUE_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // request decode
  assign accept      = req.valid && req.ready;
  assign op          = op_t'(req.mode);
  assign len_ext     = CMP_W'(length);
  assign req_pos     = (op == OP_APPEND) ? len_ext : CMP_W'(req.index);
  assign req_pos_inc = req_pos + CMP_W'(1);
  assign ins_range   = req_pos > len_ext;
  assign idx_range   = req_pos >= len_ext;
  assign full        = length == LEN_W'(CAPACITY);

  // index check takes priority over the full check
  always_comb begin
    req_status = STAT_OK;
    case (op)
      OP_INSERT, OP_APPEND: begin
        if (ins_range) begin
          req_status = STAT_RANGE;
        end else if (full) begin
          req_status = STAT_FULL;
        end
      end
      OP_SET, OP_GET, OP_REMOVE_AT: begin
        if (idx_range) req_status = STAT_RANGE;
      end
      default: ;
    endcase
  end

  assign k_dec        = k - LEN_W'(1);
  assign removed_diff = length - kept;
  assign walk_done    = (k >= length) && !pend;
  assign emit_go      = !out_valid || rsp.ready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (op)
            OP_INSERT, OP_APPEND: begin
              state_next = (ins_range || full) ? S_EMIT : S_UP;
            end
            OP_SET:          state_next = idx_range ? S_EMIT : S_SET;
            OP_GET:          state_next = idx_range ? S_EMIT : S_GET;
            OP_REMOVE_AT:    state_next = idx_range ? S_EMIT : S_DOWN;
            OP_REMOVE_VALUE: state_next = S_COMPACT;
            default:         state_next = S_EMIT;
          endcase
        end
      end
      S_UP:       if (k == pos && !pend) state_next = S_EMIT;
      S_DOWN:     if (walk_done) state_next = S_EMIT;
      S_COMPACT:  if (walk_done) state_next = S_EMIT;
      S_SET:      state_next = S_EMIT;
      S_GET:      state_next = S_GET_WAIT;
      S_GET_WAIT: state_next = S_EMIT;
      S_EMIT:     if (emit_go) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // memory and handshake controls
  always_comb begin
    req.ready = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = pend_addr;
    mem_wdata = mem_rdata;
    mem_raddr = '0;
    unique case (state)
      S_IDLE: req.ready = 1'b1;
      S_UP: begin
        mem_raddr = k_dec[AW-1:0];
        if (pend) begin
          mem_we = 1'b1;
        end else if (k == pos) begin
          mem_we    = 1'b1;
          mem_waddr = pos[AW-1:0];
          mem_wdata = word;
        end
      end
      S_DOWN: begin
        mem_raddr = k[AW-1:0];
        mem_we    = pend;
      end
      S_COMPACT: begin
        mem_raddr = k[AW-1:0];
        mem_we    = pend && (mem_rdata != word);
        mem_waddr = kept[AW-1:0];
      end
      S_SET: begin
        mem_we    = 1'b1;
        mem_waddr = pos[AW-1:0];
        mem_wdata = word;
      end
      S_GET:   mem_raddr = pos[AW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      length    <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_EMIT && emit_go) begin
        out_valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            pos         <= req_pos[LEN_W-1:0];
            word        <= VALUE_WIDTH'(req.value);
            kept        <= '0;
            pend        <= 1'b0;
            res_read    <= '0;
            res_removed <= '0;
            res_status  <= req_status;
            unique case (op)
              OP_INSERT, OP_APPEND: k <= length;
              OP_SET, OP_GET:       k <= '0;
              OP_REMOVE_AT:         k <= req_pos_inc[LEN_W-1:0];
              OP_CLEAR: begin
                k      <= '0;
                length <= '0;
              end
              default: k <= '0;
            endcase
          end
        end
        S_UP: begin
          // read k-1 now, write it to k next cycle
          pend      <= k > pos;
          pend_addr <= k[AW-1:0];
          if (k > pos) k <= k_dec;
          if (k == pos && !pend) length <= length + LEN_W'(1);
        end
        S_DOWN: begin
          pend      <= k < length;
          pend_addr <= k_dec[AW-1:0];
          if (k < length) k <= k + LEN_W'(1);
          if (walk_done) length <= k_dec;
        end
        S_COMPACT: begin
          pend <= k < length;
          if (k < length) k <= k + LEN_W'(1);
          if (pend && mem_rdata != word) kept <= kept + LEN_W'(1);
          if (walk_done) begin
            length      <= kept;
            res_removed <= COUNT_W'(removed_diff);
          end
        end
        S_GET_WAIT: res_read <= DATA_W'(mem_rdata);
        S_EMIT: begin
          if (emit_go) begin
            out_status  <= res_status;
            out_read    <= res_read;
            out_removed <= res_removed;
            out_length  <= COUNT_W'(length);
          end
        end
        default: ;
      endcase
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.read_value    = out_read;
  assign rsp.removed_count = out_removed;
  assign rsp.list_length   = out_length;

`ifndef SYNTH
  a_length_bound: assert property (@(posedge clk) disable iff (rst)
    length <= LEN_W'(CAPACITY))
    else $error("list length beyond capacity");

  a_up_walk: assert property (@(posedge clk) disable iff (rst)
    state == S_UP |-> k >= pos)
    else $error("shift-up counter passed the insert position");

  a_compact_order: assert property (@(posedge clk) disable iff (rst)
    state == S_COMPACT |-> kept <= k)
    else $error("compaction write pointer ahead of read pointer");

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !pend)
    else $error("pending shift write left over in idle");

  a_emit_load: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT && emit_go |=> rsp.valid && state == S_IDLE)
    else $error("result not loaded into output register");
`endif

endmodule

[test/ordered_array_list_checker.sv]
`timescale 1ns / 1ps

module ordered_array_list_checker
  import oal_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst,
  oal_req_if                 req,
  oal_rsp_if                 rsp,
  output int                 fail_count,
  output int                 outstanding,
  output logic [COUNT_W-1:0] tracked_length
);

  typedef struct packed {
    status_t            status;
    logic [DATA_W-1:0]  read_value;
    logic [COUNT_W-1:0] removed_count;
    logic [COUNT_W-1:0] list_length;
  } list_result_t;

  logic [DATA_W-1:0] list_words [CAPACITY];
  int unsigned       list_len;
  list_result_t      pending_results [$];

  function automatic list_result_t apply_request(input op_t op, input int unsigned idx,
                                                 input logic [DATA_W-1:0] word);
    list_result_t res;
    int unsigned  pos;
    int unsigned  kept;
    res = '0;
    res.status = STAT_OK;
    pos = (op == OP_APPEND) ? list_len : idx;
    case (op)
      OP_INSERT, OP_APPEND: begin
        // index check takes priority over the full check
        if (pos > list_len) begin
          res.status = STAT_RANGE;
        end else if (list_len >= CAPACITY) begin
          res.status = STAT_FULL;
        end else begin
          for (int unsigned k = list_len; k > pos; k--) list_words[k] = list_words[k-1];
          list_words[pos] = word;
          list_len++;
        end
      end
      OP_SET: begin
        if (pos >= list_len) res.status = STAT_RANGE;
        else list_words[pos] = word;
      end
      OP_GET: begin
        if (pos >= list_len) res.status = STAT_RANGE;
        else res.read_value = list_words[pos];
      end
      OP_REMOVE_AT: begin
        if (pos >= list_len) begin
          res.status = STAT_RANGE;
        end else begin
          for (int unsigned k = pos + 1; k < list_len; k++) list_words[k-1] = list_words[k];
          list_len--;
        end
      end
      OP_REMOVE_VALUE: begin
        kept = 0;
        for (int unsigned k = 0; k < list_len; k++) begin
          if (list_words[k] != word) begin
            list_words[kept] = list_words[k];
            kept++;
          end
        end
        res.removed_count = COUNT_W'(list_len - kept);
        list_len = kept;
      end
      OP_CLEAR: list_len = 0;
      default: ;
    endcase
    res.list_length = COUNT_W'(list_len);
    return res;
  endfunction

  always @(posedge clk) begin
    list_result_t want;
    int errs;
    errs = 0;
    if (rst) begin
      list_len = 0;
      pending_results.delete();
    end else begin
      // a result leaving on the same edge as the next request belongs to the older one
      if (rsp.valid && rsp.ready) begin
        if (pending_results.size() == 0) begin
          $error("result transaction with nothing expected: status %0d length %0d",
                 rsp.status, rsp.list_length);
          errs++;
        end else begin
          want = pending_results.pop_front();
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp.status);
            errs++;
          end
          if (rsp.read_value !== want.read_value) begin
            $error("read_value: expected %h, got %h", want.read_value, rsp.read_value);
            errs++;
          end
          if (rsp.removed_count !== want.removed_count) begin
            $error("removed_count: expected %0d, got %0d", want.removed_count,
                   rsp.removed_count);
            errs++;
          end
          if (rsp.list_length !== want.list_length) begin
            $error("list_length: expected %0d, got %0d", want.list_length, rsp.list_length);
            errs++;
          end
        end
      end
      if (req.valid && req.ready) begin
        pending_results.push_back(apply_request(op_t'(req.mode), req.index, req.value));
      end
    end
    fail_count     <= fail_count + errs;
    outstanding    <= pending_results.size();
    tracked_length <= COUNT_W'(list_len);
  end

endmodule

[test/ordered_array_list_engine_top_test.sv]
`timescale 1ns / 1ps

module ordered_array_list_engine_top_test;
  import oal_pkg::*;

  localparam int CAPACITY     = 64;
  localparam int QUIET_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 1140;
  localparam int CALM_TAIL    = 150;

  logic               clk = 1'b0;
  logic               rst;
  logic               idling;
  int                 fail_count;
  int                 outstanding;
  logic [COUNT_W-1:0] tracked_length;
  int                 quiet_cycles;
  int                 stall_left;
  logic [DATA_W-1:0]  value_pool [4];

  oal_req_if req_ch ();
  oal_rsp_if rsp_ch ();

  ordered_array_list_engine_top #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (DATA_W)
  ) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  ordered_array_list_checker #(
    .CAPACITY (CAPACITY)
  ) list_check (
    .clk            (clk),
    .rst            (rst),
    .req            (req_ch),
    .rsp            (rsp_ch),
    .fail_count     (fail_count),
    .outstanding    (outstanding),
    .tracked_length (tracked_length)
  );

  always #6 clk = ~clk;

  // result side back-pressure
  initial begin
    stall_left = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else if (idling && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 8);
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("ordered_array_list_engine_top_test: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // returns on the edge where the transaction is taken, valid left high
  task automatic send_request(input op_t op, input logic [INDEX_W-1:0] idx,
                              input logic [DATA_W-1:0] word);
    if (idling && $urandom_range(0, 5) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.mode  <= op;
    req_ch.index <= idx;
    req_ch.value <= word;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic run_random(input int count);
    int                 episode_left;
    int                 target;
    int                 len_now;
    int                 pick;
    bit                 grow;
    op_t                op;
    logic [INDEX_W-1:0] idx;
    logic [DATA_W-1:0]  word;
    episode_left = 0;
    target = 0;
    for (int n = 0; n < count; n++) begin
      if (episode_left == 0) begin
        episode_left = $urandom_range(20, 80);
        target = ($urandom_range(0, 3) == 0) ? CAPACITY : $urandom_range(0, 16);
        idling = (n < count - CALM_TAIL) && ($urandom_range(0, 2) != 0);
      end
      if (n == count - CALM_TAIL) idling = 1'b0;
      episode_left--;
      // length lags by the transaction just taken
      len_now = tracked_length;
      grow = (len_now < target);
      pick = $urandom_range(0, 99);
      if (pick < (grow ? 32 : 10)) op = OP_INSERT;
      else if (pick < (grow ? 55 : 20)) op = OP_APPEND;
      else if (pick < (grow ? 63 : 32)) op = OP_SET;
      else if (pick < (grow ? 75 : 50)) op = OP_GET;
      else if (pick < (grow ? 82 : 75)) op = OP_REMOVE_AT;
      else if (pick < (grow ? 92 : 93)) op = OP_REMOVE_VALUE;
      else if (pick < (grow ? 93 : 96)) op = OP_CLEAR;
      else op = OP_SIZE;
      case ($urandom_range(0, 9))
        0:       idx = '0;
        1:       idx = INDEX_W'(len_now);
        2:       idx = (len_now == 0) ? '0 : INDEX_W'(len_now - 1);
        3:       idx = INDEX_W'($urandom_range(len_now, 127));
        default: idx = (len_now == 0) ? '0 : INDEX_W'($urandom_range(0, len_now - 1));
      endcase
      // a small pool of repeated words gives remove value something to match
      if ($urandom_range(0, 1) == 0 && !(grow && op == OP_REMOVE_VALUE))
        word = value_pool[$urandom_range(0, 3)];
      else
        word = $urandom();
      send_request(op, idx, word);
    end
  endtask

  initial begin
    rst          <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.mode  <= OP_SIZE;
    req_ch.index <= '0;
    req_ch.value <= '0;
    idling = 1'b0;
    value_pool[0] = '0;
    value_pool[1] = '1;
    value_pool[2] = $urandom();
    value_pool[3] = $urandom();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    idling = 1'b1;
    // empty list corner cases
    send_request(OP_SIZE, 0, 0);
    send_request(OP_GET, 0, 0);
    send_request(OP_REMOVE_AT, 0, 0);
    send_request(OP_INSERT, 1, 32'h0000_0001);
    send_request(OP_REMOVE_VALUE, 0, 0);
    // head, tail and middle inserts
    send_request(OP_INSERT, 0, 32'hFFFF_FFFF);
    send_request(OP_APPEND, 0, 32'h0000_0000);
    send_request(OP_INSERT, 1, 32'hA5A5_A5A5);
    send_request(OP_INSERT, 3, 32'h5A5A_5A5A);
    send_request(OP_GET, 1, 0);
    send_request(OP_GET, 3, 0);
    send_request(OP_GET, 4, 0);
    send_request(OP_SET, 2, 32'hFFFF_FFFF);
    send_request(OP_SET, 4, 32'h1234_5678);
    send_request(OP_REMOVE_VALUE, 0, 32'hFFFF_FFFF);
    send_request(OP_REMOVE_AT, 0, 0);
    send_request(OP_REMOVE_AT, 1, 0);
    send_request(OP_CLEAR, 0, 0);

    // fill to capacity and probe the full list
    for (int k = 0; k < CAPACITY; k++)
      send_request(OP_APPEND, 0, (k % 3 == 0) ? value_pool[2] : $urandom());
    send_request(OP_APPEND, 0, 32'hDEAD_BEEF);
    send_request(OP_INSERT, 0, 0);
    send_request(OP_INSERT, 64, 0);
    send_request(OP_INSERT, 65, 0);
    send_request(OP_GET, 63, 0);
    send_request(OP_GET, 64, 0);
    send_request(OP_SET, 127, 32'hFFFF_FFFF);
    send_request(OP_REMOVE_AT, 63, 0);
    send_request(OP_REMOVE_VALUE, 0, value_pool[2]);
    send_request(OP_CLEAR, 0, 0);

    // every entry matches, so the whole list goes
    for (int k = 0; k < CAPACITY; k++)
      send_request(OP_APPEND, 0, value_pool[1]);
    send_request(OP_REMOVE_VALUE, 0, value_pool[1]);
    send_request(OP_SIZE, 0, 0);

    run_random(RANDOM_ITEMS);

    req_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("ordered_array_list_engine_top_test: PASS");
    end else begin
      $display("ordered_array_list_engine_top_test: FAIL");
    end
    $finish;
  end

endmodule
